// ===== hdl/fdef_pkg.sv =====
// Package for the framed detection event filter.
// Holds the frame byte codes, register indexes, reset values and field widths.
// Used by the filter top level and its port checker.
package fdef_pkg;

   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned MileageWidth  = 16;
   localparam int unsigned DataWidth     = ByteWidth + MileageWidth;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 16;

   localparam logic [ByteWidth-1:0] FrameStartByte = 8'h43;
   localparam logic [ByteWidth-1:0] FrameEndByte   = 8'h44;

   localparam logic [MileageWidth-1:0] TravelGapReset   = 16'd40;
   localparam logic [ByteWidth-1:0]    DistanceGapReset = 8'd20;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PARSER_ENABLE = 2'd0,
      CSR_TRAVEL_GAP    = 2'd1,
      CSR_DISTANCE_GAP  = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   typedef logic [1:0] payload_count_type;

   localparam payload_count_type PayloadNone     = 2'd0;
   localparam payload_count_type PayloadDistance = 2'd1;
   localparam payload_count_type PayloadFull     = 2'd2;

endpackage

// ===== hdl/framed_detection_event_filter_unit.sv =====
// Top level of the framed detection event filter.
// One received byte with the odometer count goes in per transfer; detection
// events come out. Depends on fdef_pkg.
//
// Usage:
//   req_* carries one serial byte and the odometer count per transfer. Bytes
//   are framed: 'C' opens a frame, 'D' closes it. The first payload byte is
//   the distance, the second the found flag; both are kept across frames.
//   rsp_* carries one event for a frame end with a nonzero flag whose
//   odometer count moved more than travel_gap from the last event, or whose
//   distance changed by at least distance_gap.
//   csr_* writes parser_enable (0), travel_gap (1) and distance_gap (2) at
//   any edge with csr_we high; writes belong to idle periods.
//   An event shows on rsp_tvalid in the cycle after the closing byte is
//   transferred. Throughput: one byte per cycle unless stalled, set by the
//   single result register; the parser state updates in the accepting cycle.
//   While an event waits on a stalled receiver, one more byte is still taken
//   only if the output register is drained in the same cycle; otherwise
//   req_tready stays low until rsp_tready rises.
//   Reset clears the parser, the last event values and the output valid, and
//   restores the register reset values.
module framed_detection_event_filter_unit
   import fdef_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [DataWidth-1:0]     req_tdata,   // rx_byte [7:0], mileage [23:8]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [DataWidth-1:0]     rsp_tdata    // target_distance [7:0], event_mileage [23:8]
);

   logic                    parser_enable_ff, parser_enable_in;
   logic [MileageWidth-1:0] travel_gap_ff, travel_gap_in;
   logic [ByteWidth-1:0]    distance_gap_ff, distance_gap_in;

   logic                    in_frame_ff, in_frame_in;
   payload_count_type       payload_count_ff, payload_count_in;
   logic [ByteWidth-1:0]    distance_byte_ff, distance_byte_in;
   logic [ByteWidth-1:0]    flag_byte_ff, flag_byte_in;
   logic [MileageWidth-1:0] last_mileage_ff, last_mileage_in;
   logic [ByteWidth-1:0]    last_distance_ff, last_distance_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DataWidth-1:0]    rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic [ByteWidth-1:0]    rx_byte;
   logic [MileageWidth-1:0] mileage;
   logic [MileageWidth-1:0] travel;
   logic [ByteWidth-1:0]    distance_change;
   logic                    emit;

   assign rx_byte = req_tdata[ByteWidth-1:0];
   assign mileage = req_tdata[DataWidth-1:ByteWidth];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign travel = (last_mileage_ff >= mileage) ? (last_mileage_ff - mileage)
                                                : (mileage - last_mileage_ff);
   assign distance_change = (distance_byte_ff >= last_distance_ff)
                            ? (distance_byte_ff - last_distance_ff)
                            : (last_distance_ff - distance_byte_ff);

   // An event needs an active frame end and a nonzero found flag.
   assign emit = accept && parser_enable_ff && in_frame_ff && (rx_byte == FrameEndByte)
                 && (flag_byte_ff != '0)
                 && ((travel > travel_gap_ff) || (distance_change >= distance_gap_ff));

   always_comb begin
      parser_enable_in = parser_enable_ff;
      travel_gap_in    = travel_gap_ff;
      distance_gap_in  = distance_gap_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PARSER_ENABLE: parser_enable_in = csr_wdata[0];
            CSR_TRAVEL_GAP:    travel_gap_in    = csr_wdata[MileageWidth-1:0];
            CSR_DISTANCE_GAP:  distance_gap_in  = csr_wdata[ByteWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_frame_in      = in_frame_ff;
      payload_count_in = payload_count_ff;
      distance_byte_in = distance_byte_ff;
      flag_byte_in     = flag_byte_ff;
      if (accept && parser_enable_ff) begin
         if (!in_frame_ff) begin
            if (rx_byte == FrameStartByte) begin
               in_frame_in      = 1'b1;
               payload_count_in = PayloadNone;
            end
         end else if (rx_byte == FrameEndByte) begin
            in_frame_in = 1'b0;
         end else begin
            // Bytes past the flag are dropped; the count saturates.
            priority if (payload_count_ff == PayloadNone) begin
               distance_byte_in = rx_byte;
               payload_count_in = PayloadDistance;
            end else if (payload_count_ff == PayloadDistance) begin
               flag_byte_in     = rx_byte;
               payload_count_in = PayloadFull;
            end else begin
               payload_count_in = payload_count_ff;
            end
         end
      end
   end

   assign last_mileage_in  = emit ? mileage : last_mileage_ff;
   assign last_distance_in = emit ? distance_byte_ff : last_distance_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {mileage, distance_byte_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parser_enable_ff <= 1'b1;
         travel_gap_ff    <= TravelGapReset;
         distance_gap_ff  <= DistanceGapReset;
         in_frame_ff      <= 1'b0;
         payload_count_ff <= PayloadNone;
         distance_byte_ff <= '0;
         flag_byte_ff     <= '0;
         last_mileage_ff  <= '0;
         last_distance_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         parser_enable_ff <= parser_enable_in;
         travel_gap_ff    <= travel_gap_in;
         distance_gap_ff  <= distance_gap_in;
         in_frame_ff      <= in_frame_in;
         payload_count_ff <= payload_count_in;
         distance_byte_ff <= distance_byte_in;
         flag_byte_ff     <= flag_byte_in;
         last_mileage_ff  <= last_mileage_in;
         last_distance_ff <= last_distance_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/fdef_port_checker.sv =====
// Port checker for the framed detection event filter, bound to its top level.
// Watches the request and response handshakes over time. Depends on fdef_pkg.
module fdef_port_checker
   import fdef_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [DataWidth-1:0] rsp_tdata
);

   // A stalled event holds its value until it is transferred.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed or dropped");

   // No event is pending in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // With the output register empty, the block always takes a byte.
   assert property (@(posedge clock) disable iff (reset) !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   // A new event only follows a request transfer in the previous cycle.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("response appeared without a request transfer");

endmodule

bind framed_detection_event_filter_unit fdef_port_checker u_fdef_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/tb_framed_detection_event_filter_unit.sv =====
// Testbench for framed_detection_event_filter_unit.
// Checks every detection event against its own frame tracker, under random idling
// on both sides in all but the last random phase. Depends on fdef_pkg and the filter top level.
module tb_framed_detection_event_filter_unit;
   import fdef_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int HoldCycles    = 240;

   typedef struct {
      logic [ByteWidth-1:0]    distance;
      logic [MileageWidth-1:0] odometer;
   } detection_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [DataWidth-1:0]     req_tdata = '0;   // rx_byte [7:0], mileage [23:8]
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [DataWidth-1:0]     rsp_tdata;        // target_distance [7:0], event_mileage [23:8]

   // Copy of the filter state and registers, advanced on every accepted byte.
   logic                    parser_on = 1'b1;
   logic [MileageWidth-1:0] travel_gap_reg = TravelGapReset;
   logic [ByteWidth-1:0]    distance_gap_reg = DistanceGapReset;
   logic                    frame_open = 1'b0;
   payload_count_type       payload_seen = PayloadNone;
   logic [ByteWidth-1:0]    held_distance = '0;
   logic [ByteWidth-1:0]    held_flag = '0;
   logic [MileageWidth-1:0] last_event_odo = '0;
   logic [ByteWidth-1:0]    last_event_distance = '0;

   detection_type expected_detections[$];

   int  bytes_sent = 0;
   int  events_checked = 0;
   int  mismatches = 0;
   int  idle_cycles = 0;
   int  rsp_hold_request = 0;
   int  rsp_hold_left = 0;
   int  rsp_stall_left = 0;
   bit  idling_on = 1'b1;
   logic [MileageWidth-1:0] trip_odo = '0;

   framed_detection_event_filter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void track_frame_byte(logic [ByteWidth-1:0] rx,
                                            logic [MileageWidth-1:0] odo);
      int travel;
      int swing;
      detection_type found;
      if (!parser_on) return;
      if (!frame_open) begin
         if (rx == FrameStartByte) begin
            frame_open = 1'b1;
            payload_seen = PayloadNone;
         end
         return;
      end
      if (rx != FrameEndByte) begin
         if (payload_seen == PayloadNone) begin
            held_distance = rx;
            payload_seen = PayloadDistance;
         end else if (payload_seen == PayloadDistance) begin
            held_flag = rx;
            payload_seen = PayloadFull;
         end
         return;
      end
      frame_open = 1'b0;
      if (held_flag == '0) return;
      travel = (odo >= last_event_odo) ? int'(odo - last_event_odo) : int'(last_event_odo - odo);
      swing = (held_distance >= last_event_distance) ? int'(held_distance - last_event_distance)
                                                     : int'(last_event_distance - held_distance);
      if (travel > int'(travel_gap_reg) || swing >= int'(distance_gap_reg)) begin
         found.distance = held_distance;
         found.odometer = odo;
         expected_detections.push_back(found);
         last_event_odo = odo;
         last_event_distance = held_distance;
      end
   endfunction

   function automatic void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
   endfunction

   // Result checker: every event transfer is matched against the oldest prediction.
   always @(posedge clock) begin
      detection_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_detections.size() == 0) begin
            note_mismatch($sformatf("unexpected event distance %0d mileage %0d",
                                    rsp_tdata[7:0], rsp_tdata[23:8]));
         end else begin
            want = expected_detections.pop_front();
            events_checked++;
            if (rsp_tdata[7:0] !== want.distance || rsp_tdata[23:8] !== want.odometer)
               note_mismatch($sformatf("expected distance %0d mileage %0d, got %0d %0d",
                                       want.distance, want.odometer,
                                       rsp_tdata[7:0], rsp_tdata[23:8]));
         end
      end
   end

   // Receiver: random stall bursts, plus a long hold-off on request.
   always @(posedge clock) begin
      if (rsp_hold_request != 0) begin
         rsp_hold_left = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left--;
      end else if (rsp_stall_left != 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left = int'($urandom_range(1, 14)) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("Timeout: no transfer for %0d cycles, %0d events outstanding",
                     WatchdogLimit, expected_detections.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Leaves req_tvalid high after the transfer; the next call or wait_drained
   // decides what it does in that same step.
   task automatic send_byte(input logic [ByteWidth-1:0] rx, input logic [MileageWidth-1:0] odo);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {odo, rx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_frame_byte(rx, odo);
      bytes_sent++;
   endtask

   task automatic send_frame_fixed(input logic [ByteWidth-1:0] distance,
                                   input logic [ByteWidth-1:0] flag,
                                   input logic [MileageWidth-1:0] odo);
      send_byte(FrameStartByte, odo);
      send_byte(distance, odo);
      send_byte(flag, odo);
      send_byte(FrameEndByte, odo);
   endtask

   // Drops req_tvalid, waits until every predicted event has been transferred,
   // and then waits on a little longer before returning.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_detections.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CsrDataWidth-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PARSER_ENABLE: parser_on = value[0];
         CSR_TRAVEL_GAP:    travel_gap_reg = value;
         CSR_DISTANCE_GAP:  distance_gap_reg = value[ByteWidth-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic test_directed_frames();
      send_byte(FrameEndByte, 16'h0000);
      send_byte(8'h00, 16'hFFFF);
      send_frame_fixed(8'hFF, 8'h01, 16'hFFFF);
      // A start byte inside a frame is taken as the distance.
      send_byte(FrameStartByte, 16'hFFFF);
      send_byte(FrameStartByte, 16'hFFFF);
      send_byte(8'h80, 16'hFFFF);
      send_byte(FrameEndByte, 16'hFFFF);
      // Overlong payload: the trailing bytes are dropped.
      send_byte(FrameStartByte, 16'h0000);
      send_byte(8'h10, 16'h0000);
      send_byte(8'hFF, 16'h0000);
      send_byte(8'hAA, 16'h0000);
      send_byte(8'h55, 16'h0000);
      send_byte(FrameEndByte, 16'h0000);
      // Empty payload reuses the stored distance and flag.
      send_byte(FrameStartByte, 16'h0029);
      send_byte(FrameEndByte, 16'h0029);
      send_frame_fixed(8'h90, 8'h00, 16'h8000);
      send_byte(FrameStartByte, 16'h8000);
      send_byte(8'h20, 16'h8000);
      send_byte(FrameEndByte, 16'h8000);
      wait_drained();
   endtask

   task automatic test_register_settings();
      csr_write(CSR_PARSER_ENABLE, 16'hFFFE);
      send_frame_fixed(8'h77, 8'h01, 16'hF000);
      wait_drained();
      csr_write(CSR_UNUSED, 16'hFFFF);
      csr_write(CSR_PARSER_ENABLE, 16'h0001);
      csr_write(CSR_TRAVEL_GAP, 16'h0000);
      send_frame_fixed(8'h10, 8'h01, 16'h0029);
      send_frame_fixed(8'h10, 8'h01, 16'h002A);
      wait_drained();
      csr_write(CSR_DISTANCE_GAP, 16'hAB00);
      send_frame_fixed(8'h00, 8'h01, 16'h002A);
      wait_drained();
      csr_write(CSR_TRAVEL_GAP, 16'hFFFF);
      csr_write(CSR_DISTANCE_GAP, 16'h00FF);
      send_frame_fixed(8'hFE, 8'h01, 16'hFFFF);
      send_frame_fixed(8'hFF, 8'h01, 16'hFFFF);
      wait_drained();
      csr_write(CSR_TRAVEL_GAP, TravelGapReset);
      csr_write(CSR_DISTANCE_GAP, 16'(DistanceGapReset));
   endtask

   // The receiver holds off while every frame emits an event, so the output
   // register fills and the input must stall.
   task automatic test_output_stall();
      rsp_hold_request = HoldCycles;
      for (int i = 0; i < 4; i++) begin
         trip_odo = trip_odo + 16'd500;
         send_frame_fixed(8'h30 + 8'(i), 8'h01, trip_odo);
      end
      wait_drained();
   endtask

   task automatic send_random_frame();
      int len;
      logic [ByteWidth-1:0] distance;
      logic [ByteWidth-1:0] flag;
      logic [ByteWidth-1:0] pick;
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3))
            send_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 9) == 0) trip_odo = 16'($urandom_range(0, 65535));
      else trip_odo = trip_odo + 16'($urandom_range(0, 60));
      case ($urandom_range(0, 9))
         0:       len = 0;
         1:       len = 1;
         8, 9:    len = 3 + int'($urandom_range(0, 2));
         default: len = 2;
      endcase
      if ($urandom_range(0, 1) == 0)
         distance = last_event_distance + 8'($urandom_range(0, 40)) - 8'd20;
      else distance = 8'($urandom_range(0, 255));
      flag = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      send_byte(FrameStartByte, 16'($urandom_range(0, 65535)));
      for (int i = 0; i < len; i++) begin
         pick = (i == 0) ? distance : (i == 1) ? flag : 8'($urandom_range(0, 255));
         if (pick == FrameEndByte) pick = FrameStartByte;
         send_byte(pick, 16'($urandom_range(0, 65535)));
      end
      // Now and then the end byte is lost and the next frame runs into this one.
      if ($urandom_range(0, 11) != 0) send_byte(FrameEndByte, trip_odo);
   endtask

   task automatic test_random_traffic();
      int stop_at;
      stop_at = bytes_sent + 80;
      while (bytes_sent < stop_at) send_random_frame();
      wait_drained();
      csr_write(CSR_TRAVEL_GAP, 16'h0000);
      csr_write(CSR_DISTANCE_GAP, 16'h0000);
      stop_at = bytes_sent + 70;
      while (bytes_sent < stop_at) send_random_frame();
      wait_drained();
      csr_write(CSR_TRAVEL_GAP, 16'hFFFF);
      csr_write(CSR_DISTANCE_GAP, 16'h00FF);
      stop_at = bytes_sent + 50;
      while (bytes_sent < stop_at) send_random_frame();
      wait_drained();
      csr_write(CSR_TRAVEL_GAP, 16'($urandom_range(0, 120)));
      csr_write(CSR_DISTANCE_GAP, 16'($urandom_range(0, 60)));
      stop_at = bytes_sent + 70;
      while (bytes_sent < stop_at) send_random_frame();
      wait_drained();
      idling_on = 1'b0;
      csr_write(CSR_TRAVEL_GAP, TravelGapReset);
      csr_write(CSR_DISTANCE_GAP, 16'(DistanceGapReset));
      stop_at = bytes_sent + 70;
      while (bytes_sent < stop_at) send_random_frame();
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_register_settings();
      test_output_stall();
      test_random_traffic();
      repeat (10) @(posedge clock);
      $display("Sent %0d bytes of framed and noise traffic; checked %0d detection events",
               bytes_sent, events_checked);
      $display("over default, zero, maximum and random gaps, parser off and a long output stall.");
      if (mismatches == 0 && expected_detections.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d events never seen", mismatches,
                  expected_detections.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== framed_detection_event_filter_unit.f =====
hdl/fdef_pkg.sv
hdl/framed_detection_event_filter_unit.sv
hdl/fdef_port_checker.sv
sim/tb_framed_detection_event_filter_unit.sv
